FILE: sv/pmfd_pkg.sv
// Shared constants and command codes of the paged monochrome frame buffer drawer.
`default_nettype none

package pmfd_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT  = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [7:0] FILL_CLEAR = 8'h00;
  localparam logic [7:0] FILL_SET   = 8'hFF;

endpackage

`default_nettype wire

FILE: sv/pmfd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module pmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/paged_monochrome_framebuffer_drawer_unit.sv
// Top level of the paged monochrome frame buffer drawer: command sequencer around the frame store.
`default_nettype none

// The frame store holds SCREEN_WIDTH x SCREEN_HEIGHT one-bit pixels in 8-row pages, one byte
// per page column, in a single RAM with one write and one registered read port. After reset
// the block runs a clearing pass over all STORE_BYTES bytes (1024 at 128x64) before it takes its
// first command word; configuration writes are taken at any time. Every on-screen pixel is
// drawn by a read-modify-write of its byte (read, then write back); a clipped one is skipped.
// Each line segment of a command passes a set-up state before its pixels, and a rectangle
// draws its four lines under one command word. Fill rewrites every byte, one per cycle, and
// ignores invert_colors. A byte read fetches its byte as the command is taken; the byte enters
// the output register from ST_RD_DATA once that register is free and holds there until the
// consumer takes it; a read index beyond the store returns zero.
module paged_monochrome_framebuffer_drawer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        invert_colors_i,
  // Command channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  x_first_i,
  input  wire logic [7:0]  x_last_i,
  input  wire logic [7:0]  y_first_i,
  input  wire logic [7:0]  y_last_i,
  input  wire logic        color_i,
  input  wire logic [9:0]  byte_index_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [9:0]  read_index_o,
  output logic      [7:0]  read_data_o
);

  localparam int AW = pmfd_pkg::ADDR_W;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_SEG     = 7'b0000100,
    ST_PIX     = 7'b0001000,
    ST_PIX_WR  = 7'b0010000,
    ST_RD_DATA = 7'b0100000,
    ST_SPARE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic          invert_q;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          fill_q, fill_d;
  logic [1:0]    seg_q, seg_d;
  logic [7:0]    cur_q, cur_d;
  logic          out_valid_q;

  // Command fields, captured when a command word is taken.
  logic [2:0] op_q;
  logic [7:0] x1_q, x2_q, y1_q, y2_q;
  logic       color_q;
  logic [9:0] bidx_q;

  logic [9:0] read_index_q;
  logic [7:0] read_data_q;

  logic accept;
  logic load_out;
  logic advance;

  // RAM port signals.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Current segment of the command. A pixel is a one-pixel horizontal line, and a rectangle
  // walks its top, bottom, left and right edges in that order.
  logic       seg_vert;
  logic [7:0] seg_fixed, seg_start, seg_end;
  logic       seg_last;
  logic       seg_done;

  always_comb begin
    seg_vert = (op_q == pmfd_pkg::OP_VLINE) || ((op_q == pmfd_pkg::OP_RECT) && seg_q[1]);
    seg_last = (op_q != pmfd_pkg::OP_RECT) || (seg_q == 2'd3);
    if (seg_vert) begin
      seg_fixed = ((op_q == pmfd_pkg::OP_RECT) && (seg_q == 2'd3)) ? x2_q : x1_q;
      seg_start = y1_q;
      seg_end   = y2_q;
    end else begin
      seg_fixed = ((op_q == pmfd_pkg::OP_RECT) && (seg_q == 2'd1)) ? y2_q : y1_q;
      seg_start = x1_q;
      seg_end   = (op_q == pmfd_pkg::OP_PIXEL) ? x1_q : x2_q;
    end
  end

  assign seg_done = (cur_q == seg_end);

  // Pixel under the walker, its byte address and its bit inside the byte.
  logic [7:0]    pix_x, pix_y;
  logic          pix_on;
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;

  assign pix_x    = seg_vert ? seg_fixed : cur_q;
  assign pix_y    = seg_vert ? cur_q : seg_fixed;
  assign pix_on   = (32'(pix_x) < 32'(pmfd_pkg::SCREEN_WIDTH)) &&
                    (32'(pix_y) < 32'(pmfd_pkg::SCREEN_HEIGHT));
  assign pix_addr = AW'(32'(pix_x) + 32'(pix_y[7:3]) * pmfd_pkg::SCREEN_WIDTH);
  assign pix_mask = 8'd1 << pix_y[2:0];

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    fill_d    = fill_q;
    seg_d     = seg_q;
    cur_d     = cur_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pix_addr;
    ram_raddr = pix_addr;
    ram_wdata = color_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
    load_out  = 1'b0;
    advance   = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // Sweep the whole store with the fill byte, one byte a cycle.
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = fill_q ? pmfd_pkg::FILL_SET : pmfd_pkg::FILL_CLEAR;
        if (sweep_q == AW'(pmfd_pkg::STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            pmfd_pkg::OP_PIXEL, pmfd_pkg::OP_HLINE,
            pmfd_pkg::OP_VLINE, pmfd_pkg::OP_RECT: begin
              seg_d   = 2'd0;
              state_d = ST_SEG;
            end
            pmfd_pkg::OP_FILL: begin
              sweep_d = '0;
              fill_d  = color_i;
              state_d = ST_CLEAR;
            end
            pmfd_pkg::OP_READ: begin
              // The read goes out straight from the command word.
              ram_re    = 1'b1;
              ram_raddr = AW'(byte_index_i);
              state_d   = ST_RD_DATA;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEG: begin
        // A reversed segment draws nothing.
        if (seg_end < seg_start) begin
          if (seg_last) begin
            state_d = ST_IDLE;
          end else begin
            seg_d = seg_q + 2'd1;
          end
        end else begin
          cur_d   = seg_start;
          state_d = ST_PIX;
        end
      end
      ST_PIX: begin
        if (pix_on) begin
          ram_re  = 1'b1;
          state_d = ST_PIX_WR;
        end else begin
          advance = 1'b1;
        end
      end
      ST_PIX_WR: begin
        // The walker has not moved, so pix_addr is the byte read in the last cycle.
        ram_we  = 1'b1;
        advance = 1'b1;
      end
      ST_RD_DATA: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      if (seg_done) begin
        if (seg_last) begin
          state_d = ST_IDLE;
        end else begin
          seg_d   = seg_q + 2'd1;
          state_d = ST_SEG;
        end
      end else begin
        cur_d   = cur_q + 8'd1;
        state_d = ST_PIX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      fill_q      <= 1'b0;
      seg_q       <= 2'd0;
      cur_q       <= 8'd0;
      invert_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      fill_q   <= fill_d;
      seg_q    <= seg_d;
      cur_q    <= cur_d;
      if (cfg_valid_i && cfg_ready_o) begin
        invert_q <= invert_colors_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      x1_q    <= x_first_i;
      x2_q    <= x_last_i;
      y1_q    <= y_first_i;
      y2_q    <= y_last_i;
      color_q <= color_i ^ invert_q;
      bidx_q  <= byte_index_i;
    end
    if (load_out) begin
      read_index_q <= bidx_q;
      read_data_q  <= (32'(bidx_q) < 32'(pmfd_pkg::STORE_BYTES)) ? ram_rdata : 8'd0;
    end
  end

  pmfd_ram #(
    .WIDTH(8),
    .DEPTH(pmfd_pkg::STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_index_o = read_index_q;
  assign read_data_o  = read_data_q;

  // The sequencer never reads and writes the same byte in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && ram_we && (ram_raddr == ram_waddr)))
    else $error("frame store read and write collide on one byte");

  // A write-back goes to the byte fetched in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX_WR) |-> (ram_waddr == $past(ram_raddr)) && $past(ram_re))
    else $error("write-back address differs from the fetched byte");

  // A result word appears only out of a byte read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RD_DATA))
    else $error("result word raised outside a byte read");

endmodule

`default_nettype wire

FILE: tb/tb_paged_monochrome_framebuffer_drawer_unit.sv
// Self-checking testbench for the paged monochrome frame buffer drawer, with a shadow frame store.
module tb_paged_monochrome_framebuffer_drawer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Package constants used throughout the bench.
  localparam int         SCREEN_WIDTH  = pmfd_pkg::SCREEN_WIDTH;
  localparam int         SCREEN_HEIGHT = pmfd_pkg::SCREEN_HEIGHT;
  localparam int         STORE_BYTES   = pmfd_pkg::STORE_BYTES;
  localparam logic [2:0] OP_PIXEL      = pmfd_pkg::OP_PIXEL;
  localparam logic [2:0] OP_HLINE      = pmfd_pkg::OP_HLINE;
  localparam logic [2:0] OP_VLINE      = pmfd_pkg::OP_VLINE;
  localparam logic [2:0] OP_RECT       = pmfd_pkg::OP_RECT;
  localparam logic [2:0] OP_FILL       = pmfd_pkg::OP_FILL;
  localparam logic [2:0] OP_READ       = pmfd_pkg::OP_READ;
  localparam logic [7:0] FILL_CLEAR    = pmfd_pkg::FILL_CLEAR;
  localparam logic [7:0] FILL_SET      = pmfd_pkg::FILL_SET;

  // Op codes 6 and 7 are unused by the block; they must be swallowed without a result word.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  // A rectangle spanning the whole 8-bit coordinate range keeps the block busy longest; the
  // drain is sized to let such a command finish before the invert bit is rewritten.
  localparam int DRAIN_CYCLES  = 1500;
  localparam int PHASE_ITEMS   = 200;
  localparam int RANDOM_PHASES = 8;
  // The worst correct run is about 1625 commands, each at most a full-range rectangle, plus the
  // clearing pass and the drains between phases; the limit takes that several times over.
  localparam int CYCLE_LIMIT   = 8_000_000;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x_first;
    logic [7:0] x_last;
    logic [7:0] y_first;
    logic [7:0] y_last;
    logic       color;
    logic [9:0] byte_index;
  } draw_cmd_t;

  typedef struct {
    logic [9:0] index;
    logic [7:0] data;
  } readback_t;

  // The scoreboard keeps a shadow copy of the frame store. Every accepted command word is
  // applied to it in order, and each byte read queues the word the block must return.
  class readback_scoreboard;
    logic [7:0] shadow_frame [STORE_BYTES];
    bit         invert;
    readback_t  expected_reads [$];
    int         mismatches;
    int         reads_checked;

    function new();
      foreach (shadow_frame[i]) shadow_frame[i] = FILL_CLEAR;
      invert        = 1'b0;
      mismatches    = 0;
      reads_checked = 0;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    // One pixel: clipped when off screen, colour flipped by the invert bit.
    function void plot(int x, int y, bit color);
      int idx;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      idx = x + (y / 8) * SCREEN_WIDTH;
      shadow_frame[idx][y % 8] = color ^ invert;
    endfunction

    // A line whose end lies before its start draws nothing, which the loop bounds give for free.
    function void draw_row(int xa, int xb, int y, bit color);
      for (int i = xa; i <= xb; i++) plot(i, y, color);
    endfunction

    function void draw_column(int ya, int yb, int x, bit color);
      for (int i = ya; i <= yb; i++) plot(x, i, color);
    endfunction

    function void note_command(draw_cmd_t c);
      readback_t r;
      case (c.op)
        OP_PIXEL: plot(c.x_first, c.y_first, c.color);
        OP_HLINE: draw_row(c.x_first, c.x_last, c.y_first, c.color);
        OP_VLINE: draw_column(c.y_first, c.y_last, c.x_first, c.color);
        OP_RECT: begin
          draw_row(c.x_first, c.x_last, c.y_first, c.color);
          draw_row(c.x_first, c.x_last, c.y_last, c.color);
          draw_column(c.y_first, c.y_last, c.x_first, c.color);
          draw_column(c.y_first, c.y_last, c.x_last, c.color);
        end
        OP_FILL: begin
          foreach (shadow_frame[i]) shadow_frame[i] = c.color ? FILL_SET : FILL_CLEAR;
        end
        OP_READ: begin
          r.index = c.byte_index;
          r.data  = (c.byte_index < STORE_BYTES) ? shadow_frame[c.byte_index] : FILL_CLEAR;
          expected_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 200) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_readback(logic [9:0] idx, logic [7:0] data);
      readback_t want;
      if (expected_reads.size() == 0) begin
        report($sformatf("result word with no read waiting: index %0d data %02h", idx, data));
        return;
      end
      want = expected_reads.pop_front();
      reads_checked++;
      if (idx !== want.index)
        report($sformatf("read_index %0d, wanted %0d", idx, want.index));
      if (data !== want.data)
        report($sformatf("read_data %02h at index %0d, wanted %02h", data, want.index,
                         want.data));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_invert;
  logic       in_valid;
  logic [2:0] op;
  logic [7:0] x_first;
  logic [7:0] x_last;
  logic [7:0] y_first;
  logic [7:0] y_last;
  logic       color;
  logic [9:0] byte_index;
  logic       out_ready;
  logic       cfg_ready_o;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [9:0] read_index_o;
  logic [7:0] read_data_o;

  readback_scoreboard board;
  draw_cmd_t          batch [$];
  bit                 sender_idle;
  bit                 receiver_idle;
  int                 commands_sent;
  int                 recent_x;
  int                 recent_y;
  bit [1:0]           settings_seen;

  paged_monochrome_framebuffer_drawer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .invert_colors_i (cfg_invert),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .op_i            (op),
    .x_first_i       (x_first),
    .x_last_i        (x_last),
    .y_first_i       (y_first),
    .y_last_i        (y_last),
    .color_i         (color),
    .byte_index_i    (byte_index),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .read_index_o    (read_index_o),
    .read_data_o     (read_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: ready drops in short random bursts while receiver idling is enabled.
  always begin : result_sink
    @(posedge clk_i);
    if (receiver_idle && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    out_ready <= 1'b1;
  end

  // Every result word taken at an edge is checked against the oldest pending read.
  always @(posedge clk_i) begin : result_monitor
    if (rst_ni && out_valid_o && out_ready)
      board.check_readback(read_index_o, read_data_o);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic draw_cmd_t make_cmd(logic [2:0] c_op, int xf, int xl, int yf, int yl,
                                         bit c_color, int idx);
    draw_cmd_t c;
    c.op         = c_op;
    c.x_first    = 8'(xf);
    c.x_last     = 8'(xl);
    c.y_first    = 8'(yf);
    c.y_last     = 8'(yl);
    c.color      = c_color;
    c.byte_index = 10'(idx);
    return c;
  endfunction

  // Mostly on-screen coordinates, with the screen edges and the full 8-bit range now and then.
  function automatic logic [7:0] pick_coord(int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return 8'(limit - 1 + $urandom_range(0, 1));
    if (r == 2) return 8'h00;
    return 8'($urandom_range(0, limit - 1));
  endfunction

  // Line ends are mostly short spans after the start; some are reversed, some anywhere.
  function automatic logic [7:0] pick_end(logic [7:0] first);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return first - 8'($urandom_range(1, 8));
    return first + 8'($urandom_range(0, 15));
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int        pick;
    // Unused fields still carry random bits so the block is seen to ignore them.
    c.x_first    = 8'($urandom);
    c.x_last     = 8'($urandom);
    c.y_first    = 8'($urandom);
    c.y_last     = 8'($urandom);
    c.color      = 1'($urandom);
    c.byte_index = 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.op = OP_PIXEL;
    else if (pick < 40) c.op = OP_HLINE;
    else if (pick < 55) c.op = OP_VLINE;
    else if (pick < 65) c.op = OP_RECT;
    else if (pick < 68) c.op = OP_FILL;
    else if (pick < 70) c.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    else                c.op = OP_READ;
    if (c.op inside {OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT}) begin
      c.x_first = pick_coord(SCREEN_WIDTH);
      c.y_first = pick_coord(SCREEN_HEIGHT);
      c.x_last  = pick_end(c.x_first);
      c.y_last  = pick_end(c.y_first);
      if (c.x_first < SCREEN_WIDTH && c.y_first < SCREEN_HEIGHT) begin
        recent_x = c.x_first;
        recent_y = c.y_first;
      end
    end
    // Half the reads look at a byte that was just drawn, so they see real pixel data.
    if (c.op == OP_READ && $urandom_range(0, 1))
      c.byte_index = 10'(recent_x + (recent_y / 8) * SCREEN_WIDTH);
    return c;
  endfunction

  // Drives every command word in the batch. Valid stays high between back-to-back words and
  // is only lowered for a gap or after the last word, so it is never dropped and raised in
  // one step.
  task automatic drive_batch();
    foreach (batch[i]) begin
      if (sender_idle && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      in_valid   <= 1'b1;
      op         <= batch[i].op;
      x_first    <= batch[i].x_first;
      x_last     <= batch[i].x_last;
      y_first    <= batch[i].y_first;
      y_last     <= batch[i].y_last;
      color      <= batch[i].color;
      byte_index <= batch[i].byte_index;
      do @(posedge clk_i); while (!in_ready_o);
      board.note_command(batch[i]);
      commands_sent++;
    end
    in_valid <= 1'b0;
    batch.delete();
  endtask

  // Drawing commands give no result word, so after the last read returns the block may still
  // be drawing; the extra cycles cover the longest command before the invert bit changes.
  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_invert(bit value);
    cfg_invert <= value;
    cfg_valid  <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.invert = value;
    settings_seen[value] = 1'b1;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int directed_count;
    board         = new();
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_invert    = 1'b0;
    in_valid      = 1'b0;
    op            = OP_PIXEL;
    x_first       = 8'h00;
    x_last        = 8'h00;
    y_first       = 8'h00;
    y_last        = 8'h00;
    color         = 1'b0;
    byte_index    = 10'd0;
    out_ready     = 1'b0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    commands_sent = 0;
    recent_x      = 0;
    recent_y      = 0;
    settings_seen = 2'b00;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block clears its store after reset; the command handshake simply waits that pass out.
    write_invert(1'b0);

    // Directed words: reset contents, corner pixels, clipping in x and y, full-width and
    // reversed lines, a rectangle, an erase, the spare op codes and both fills.
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, STORE_BYTES - 1));
    batch.push_back(make_cmd(OP_PIXEL, 0, 0, 0, 0, 1, 0));
    batch.push_back(make_cmd(OP_PIXEL, SCREEN_WIDTH - 1, 0, SCREEN_HEIGHT - 1, 0, 1, 0));
    batch.push_back(make_cmd(OP_PIXEL, SCREEN_WIDTH, 0, 5, 0, 1, 0));
    batch.push_back(make_cmd(OP_PIXEL, 5, 0, SCREEN_HEIGHT, 0, 1, 0));
    batch.push_back(make_cmd(OP_PIXEL, 255, 255, 255, 255, 1, 1023));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, STORE_BYTES - 1));
    batch.push_back(make_cmd(OP_HLINE, 0, SCREEN_WIDTH - 1, 9, 0, 1, 0));
    batch.push_back(make_cmd(OP_HLINE, 10, 5, 17, 0, 1, 0));
    batch.push_back(make_cmd(OP_VLINE, 3, 0, 0, SCREEN_HEIGHT - 1, 1, 0));
    batch.push_back(make_cmd(OP_VLINE, 4, 0, 20, 10, 1, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 1 + SCREEN_WIDTH));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 3 + 4 * SCREEN_WIDTH));
    batch.push_back(make_cmd(OP_RECT,  20, 40, 30, 50, 1, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 20 + 3 * SCREEN_WIDTH));
    batch.push_back(make_cmd(OP_PIXEL, 20, 0, 30, 0, 0, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 20 + 3 * SCREEN_WIDTH));
    batch.push_back(make_cmd(OP_SPARE_A, 1, 2, 3, 4, 1, 5));
    batch.push_back(make_cmd(OP_SPARE_B, 255, 255, 255, 255, 1, 1023));
    batch.push_back(make_cmd(OP_FILL,  0, 0, 0, 0, 1, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 777));
    batch.push_back(make_cmd(OP_FILL,  0, 0, 0, 0, 0, 0));
    batch.push_back(make_cmd(OP_READ,  0, 0, 0, 0, 0, 900));
    directed_count = batch.size();
    drive_batch();

    // Random phases, each under its own invert setting. Idling is switched per phase so some
    // stretches run with none, and the last phase runs flat out on both sides.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 0)      write_invert(1'b1);
      else if (phase == 1) write_invert(1'b0);
      else                 write_invert(1'($urandom_range(0, 1)));
      sender_idle   = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      receiver_idle = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) batch.push_back(random_cmd());
      drive_batch();
    end

    wait_idle();

    $display("Drove %0d command words (%0d directed), invert settings used: %02b.",
             commands_sent, directed_count, settings_seen);
    $display("Compared %0d read-back words, %0d mismatches.", board.reads_checked,
             board.mismatches);
    if (board.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
